@@ rtl/assert_macros.svh @@
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/owbm_pkg.sv @@
package owbm_pkg;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// sequencer phases
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_POLL = 4'd3;
	localparam logic [3:0] PH_RST_RISE = 4'd4;
	localparam logic [3:0] PH_W_LOW    = 4'd5;
	localparam logic [3:0] PH_W_HOLD   = 4'd6;
	localparam logic [3:0] PH_W_REC    = 4'd7;
	localparam logic [3:0] PH_R_LOW    = 4'd8;
	localparam logic [3:0] PH_R_SAMPLE = 4'd9;
	localparam logic [3:0] PH_R_TAIL   = 4'd10;
	localparam logic [3:0] PH_R_RISE   = 4'd11;

	// configuration register indexes
	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRES_DELAY    = 3'd1;
	localparam logic [2:0] REG_PRES_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
	localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
	localparam logic [2:0] REG_RECOVERY      = 3'd5;
	localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [2:0] REG_READ_TAIL     = 3'd7;

	// register reset values
	localparam logic [15:0] RST_RESET_LOW    = 16'd90;
	localparam logic [15:0] RST_PRES_DELAY   = 16'd11;
	localparam logic [15:0] RST_PRES_TIMEOUT = 16'd60000;
	localparam logic [7:0]  RST_SLOT_LOW     = 8'd1;
	localparam logic [7:0]  RST_WRITE_HOLD   = 8'd8;
	localparam logic [7:0]  RST_RECOVERY     = 8'd1;
	localparam logic [7:0]  RST_READ_SAMPLE  = 8'd6;
	localparam logic [7:0]  RST_READ_TAIL    = 8'd8;

	typedef struct packed {
		logic [15:0] reset_low_ticks;
		logic [15:0] presence_delay_ticks;
		logic [15:0] presence_timeout_ticks;
		logic [7:0]  slot_low_ticks;
		logic [7:0]  write_hold_ticks;
		logic [7:0]  recovery_ticks;
		logic [7:0]  read_sample_ticks;
		logic [7:0]  read_tail_ticks;
	} cfg_t;

	typedef struct packed {
		logic       presence_timed_out;
		logic       device_present;
		logic [7:0] read_value;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} res_t;

endpackage

@@ rtl/owbm_cfg.sv @@
module owbm_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [2:0]      wr_index,
	input  logic [15:0]     wr_data,
	output owbm_pkg::cfg_t  cfg
);
	import owbm_pkg::*;

	cfg_t cfg_q;

	// register file, one write per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks        <= RST_RESET_LOW;
			cfg_q.presence_delay_ticks   <= RST_PRES_DELAY;
			cfg_q.presence_timeout_ticks <= RST_PRES_TIMEOUT;
			cfg_q.slot_low_ticks         <= RST_SLOT_LOW;
			cfg_q.write_hold_ticks       <= RST_WRITE_HOLD;
			cfg_q.recovery_ticks         <= RST_RECOVERY;
			cfg_q.read_sample_ticks      <= RST_READ_SAMPLE;
			cfg_q.read_tail_ticks        <= RST_READ_TAIL;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESET_LOW:    cfg_q.reset_low_ticks        <= wr_data;
				REG_PRES_DELAY:   cfg_q.presence_delay_ticks   <= wr_data;
				REG_PRES_TIMEOUT: cfg_q.presence_timeout_ticks <= wr_data;
				REG_SLOT_LOW:     cfg_q.slot_low_ticks         <= wr_data[7:0];
				REG_WRITE_HOLD:   cfg_q.write_hold_ticks       <= wr_data[7:0];
				REG_RECOVERY:     cfg_q.recovery_ticks         <= wr_data[7:0];
				REG_READ_SAMPLE:  cfg_q.read_sample_ticks      <= wr_data[7:0];
				REG_READ_TAIL:    cfg_q.read_tail_ticks        <= wr_data[7:0];
				default:          cfg_q.read_tail_ticks        <= cfg_q.read_tail_ticks;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/owbm_seq.sv @@
module owbm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [1:0]      kind,
	input  logic [7:0]      data_byte,
	input  logic            line_level,
	input  owbm_pkg::cfg_t  cfg,
	output owbm_pkg::res_t  res
);
	import owbm_pkg::*;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] ticks_q, ticks_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic        present_q, present_d;
	logic        timeout_q, timeout_d;
	logic [7:0]  rdres_q, rdres_d;
	logic        done;
	logic [15:0] ticks_inc;
	logic [15:0] len;
	logic        elapsed;

	// phase length for the timed phase now running
	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:  len = cfg.reset_low_ticks;
			PH_RST_WAIT: len = cfg.presence_delay_ticks;
			PH_RST_POLL: len = cfg.presence_timeout_ticks;
			PH_W_LOW:    len = {8'd0, cfg.slot_low_ticks};
			PH_R_LOW:    len = {8'd0, cfg.slot_low_ticks};
			PH_W_HOLD:   len = {8'd0, cfg.write_hold_ticks};
			PH_W_REC:    len = {8'd0, cfg.recovery_ticks};
			PH_R_SAMPLE: len = {8'd0, cfg.read_sample_ticks};
			PH_R_TAIL:   len = {8'd0, cfg.read_tail_ticks};
			default:     len = 16'd0;
		endcase
	end

	assign ticks_inc = ticks_q + 16'd1;
	assign elapsed   = (ticks_inc >= len);

	// next state for one item
	always_comb begin
		phase_d   = phase_q;
		ticks_d   = ticks_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		present_d = present_q;
		timeout_d = timeout_q;
		rdres_d   = rdres_q;
		done      = 1'b0;
		if (kind != KIND_TICK) begin
			// commands start only from idle
			if (phase_q == PH_IDLE) begin
				bit_d   = 3'd0;
				ticks_d = 16'd0;
				unique case (kind)
					KIND_RESET: begin
						present_d = 1'b0;
						timeout_d = 1'b0;
						phase_d   = PH_RST_LOW;
					end
					KIND_WRITE: begin
						shift_d = data_byte;
						phase_d = PH_W_LOW;
					end
					default: begin
						shift_d = 8'd0;
						phase_d = PH_R_LOW;
					end
				endcase
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d = PH_IDLE;
				end
				PH_RST_LOW, PH_RST_WAIT, PH_W_LOW, PH_W_HOLD, PH_R_LOW, PH_R_TAIL: begin
					ticks_d = ticks_inc;
					if (elapsed) begin
						ticks_d = 16'd0;
						unique case (phase_q)
							PH_RST_LOW:  phase_d = PH_RST_WAIT;
							PH_RST_WAIT: phase_d = PH_RST_POLL;
							PH_W_LOW:    phase_d = PH_W_HOLD;
							PH_W_HOLD:   phase_d = PH_W_REC;
							PH_R_LOW:    phase_d = PH_R_SAMPLE;
							default:     phase_d = PH_R_RISE;
						endcase
					end
				end
				PH_RST_POLL: begin
					if (!line_level) begin
						present_d = 1'b1;
						ticks_d   = 16'd0;
						phase_d   = PH_RST_RISE;
					end else begin
						ticks_d = ticks_inc;
						if (elapsed) begin
							timeout_d = 1'b1;
							present_d = 1'b0;
							ticks_d   = 16'd0;
							phase_d   = PH_IDLE;
							done      = 1'b1;
						end
					end
				end
				PH_RST_RISE: begin
					if (line_level) begin
						ticks_d = 16'd0;
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
				end
				PH_W_REC: begin
					ticks_d = ticks_inc;
					if (elapsed) begin
						shift_d = {1'b0, shift_q[7:1]};
						ticks_d = 16'd0;
						if (bit_q == 3'd7) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_W_LOW;
						end
					end
				end
				PH_R_SAMPLE: begin
					ticks_d = ticks_inc;
					if (elapsed) begin
						shift_d = {line_level, shift_q[7:1]};
						ticks_d = 16'd0;
						phase_d = PH_R_TAIL;
					end
				end
				PH_R_RISE: begin
					if (line_level) begin
						ticks_d = 16'd0;
						if (bit_q == 3'd7) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
							rdres_d = shift_q;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_R_LOW;
						end
					end
				end
				default: begin
					ticks_d = 16'd0;
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// sequencer state, advanced once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			ticks_q   <= 16'd0;
			bit_q     <= 3'd0;
			shift_q   <= 8'd0;
			present_q <= 1'b0;
			timeout_q <= 1'b0;
			rdres_q   <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			ticks_q   <= ticks_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			present_q <= present_d;
			timeout_q <= timeout_d;
			rdres_q   <= rdres_d;
		end
	end

	// result as seen after the item is applied
	always_comb begin
		if (phase_d == PH_RST_LOW || phase_d == PH_W_LOW || phase_d == PH_R_LOW) begin
			res.drive_low = 1'b1;
		end else if (phase_d == PH_W_HOLD) begin
			res.drive_low = ~shift_d[0];
		end else begin
			res.drive_low = 1'b0;
		end
		res.busy_res           = (phase_d != PH_IDLE);
		res.done_res           = done;
		res.read_value         = rdres_d;
		res.device_present     = present_d;
		res.presence_timed_out = timeout_d;
	end

endmodule

@@ rtl/one_wire_bus_master_top.sv @@
// One-wire bus master, driven by a stream of items on the s_ channel.
// Each item is either a one-microsecond tick carrying the sampled bus level
// or a command (bus reset, write byte, read byte). Commands are taken only
// when the sequencer is idle; a command that arrives while busy is dropped
// and still yields a status result. Every item yields exactly one result on
// the m_ channel: bus drive level, busy, done, last read byte and presence
// flags, all as they stand after that item.
// Path: the item's transfer loads the input register, and the result
// register then loads after one pass through the sequencer, held while the
// m_ receiver stalls. Throughput: one item per cycle while the m_ receiver
// takes results; the sequencer state updates once per item.
// If the m_ receiver stalls, the result register holds and the input
// register fills, after which s_tready falls until the result is taken.
// Configuration writes on the cfg_ channel are always accepted, cfg_ready
// being tied high, and are meant to be done while the bus is idle.
// Reset (arst_n low) returns the sequencer to idle, clears flags and the read
// byte, restores default phase lengths and empties both registers.
`include "assert_macros.svh"
module one_wire_bus_master_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, [15:9] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                               // [10:3] read_value, [11] device_present,
	                               // [12] presence_timed_out, [15:13] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import owbm_pkg::*;

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] data_s1;
	logic       level_s1;
	logic       out_valid_q;
	logic       adv;
	logic       step;

	// configuration writes always complete at once
	assign cfg_ready = 1'b1;

	owbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// pipeline moves when the result register is free or being taken
	assign adv      = !out_valid_q || m_tready;
	assign step     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			data_s1  <= s_tdata[7:0];
			level_s1 <= s_tdata[8];
		end
	end

	owbm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.kind       (kind_s1),
		.data_byte  (data_s1),
		.line_level (level_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, res_q};

	// sequencer invariants and pipeline control checks
	`ASSERT_SAME(a_done_not_busy, m_tvalid, !(res_q.done_res && res_q.busy_res), "done while busy")
	`ASSERT_SAME(a_flags_excl, m_tvalid, !(res_q.device_present && res_q.presence_timed_out), "present and timed out")
	`ASSERT_SAME(a_drive_busy, m_tvalid && res_q.drive_low, res_q.busy_res, "bus driven while idle")
	`ASSERT_SAME(a_full_stall, valid_s1 && m_tvalid && !m_tready, !s_tready, "input taken while full")

endmodule

@@ bench/one_wire_bus_master_top_test.sv @@
module one_wire_bus_master_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import owbm_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;

	// mirror of the sequencer: predicts the status word for every item
	class bus_status_board;
		cfg_t        cfg;
		logic [3:0]  seq_phase;
		logic [15:0] slot_ticks;
		logic [2:0]  bit_pos;
		logic [7:0]  shift_reg;
		logic        present;
		logic        timed_out;
		logic [7:0]  last_read;
		res_t        expected_status[$];
		int          errors;
		int          finished;
		int          timeouts;

		function new();
			cfg = '{RST_RESET_LOW, RST_PRES_DELAY, RST_PRES_TIMEOUT, RST_SLOT_LOW,
				RST_WRITE_HOLD, RST_RECOVERY, RST_READ_SAMPLE, RST_READ_TAIL};
			seq_phase = PH_IDLE;
			slot_ticks = '0;
			bit_pos = '0;
			shift_reg = '0;
			present = 1'b0;
			timed_out = 1'b0;
			last_read = '0;
			errors = 0;
			finished = 0;
			timeouts = 0;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_RESET_LOW:    cfg.reset_low_ticks = val;
				REG_PRES_DELAY:   cfg.presence_delay_ticks = val;
				REG_PRES_TIMEOUT: cfg.presence_timeout_ticks = val;
				REG_SLOT_LOW:     cfg.slot_low_ticks = val[7:0];
				REG_WRITE_HOLD:   cfg.write_hold_ticks = val[7:0];
				REG_RECOVERY:     cfg.recovery_ticks = val[7:0];
				REG_READ_SAMPLE:  cfg.read_sample_ticks = val[7:0];
				REG_READ_TAIL:    cfg.read_tail_ticks = val[7:0];
			endcase
		endfunction

		function void go_to(logic [3:0] p);
			seq_phase = p;
			slot_ticks = '0;
		endfunction

		// a timed phase lasts at least one tick, even with zero length
		function bit phase_done(logic [15:0] span);
			slot_ticks = slot_ticks + 16'd1;
			return slot_ticks >= span;
		endfunction

		// close a bit slot; returns 1 once the eighth bit is through
		function bit end_slot(logic [3:0] low_phase);
			if (bit_pos == 3'd7) begin
				go_to(PH_IDLE);
				return 1'b1;
			end
			bit_pos = bit_pos + 3'd1;
			go_to(low_phase);
			return 1'b0;
		endfunction

		// apply one accepted item and queue the status it should produce
		function void take_item(logic [1:0] kind, logic [7:0] data, logic level);
			res_t r;
			bit fin;
			fin = 1'b0;
			if (kind != KIND_TICK) begin
				// commands only start from idle
				if (seq_phase == PH_IDLE) begin
					bit_pos = '0;
					case (kind)
						KIND_RESET: begin
							present = 1'b0;
							timed_out = 1'b0;
							go_to(PH_RST_LOW);
						end
						KIND_WRITE: begin
							shift_reg = data;
							go_to(PH_W_LOW);
						end
						default: begin
							shift_reg = '0;
							go_to(PH_R_LOW);
						end
					endcase
				end
			end else begin
				case (seq_phase)
					PH_RST_LOW:
						if (phase_done(cfg.reset_low_ticks)) go_to(PH_RST_WAIT);
					PH_RST_WAIT:
						if (phase_done(cfg.presence_delay_ticks)) go_to(PH_RST_POLL);
					PH_RST_POLL: begin
						if (!level) begin
							present = 1'b1;
							go_to(PH_RST_RISE);
						end else if (phase_done(cfg.presence_timeout_ticks)) begin
							timed_out = 1'b1;
							present = 1'b0;
							go_to(PH_IDLE);
							fin = 1'b1;
							timeouts++;
						end
					end
					PH_RST_RISE: begin
						if (level) begin
							go_to(PH_IDLE);
							fin = 1'b1;
						end
					end
					PH_W_LOW:
						if (phase_done(cfg.slot_low_ticks)) go_to(PH_W_HOLD);
					PH_W_HOLD:
						if (phase_done(cfg.write_hold_ticks)) go_to(PH_W_REC);
					PH_W_REC: begin
						if (phase_done(cfg.recovery_ticks)) begin
							shift_reg = shift_reg >> 1;
							fin = end_slot(PH_W_LOW);
						end
					end
					PH_R_LOW:
						if (phase_done(cfg.slot_low_ticks)) go_to(PH_R_SAMPLE);
					PH_R_SAMPLE: begin
						if (phase_done(cfg.read_sample_ticks)) begin
							shift_reg = {level, shift_reg[7:1]};
							go_to(PH_R_TAIL);
						end
					end
					PH_R_TAIL:
						if (phase_done(cfg.read_tail_ticks)) go_to(PH_R_RISE);
					PH_R_RISE: begin
						if (level) begin
							fin = end_slot(PH_R_LOW);
							if (fin) last_read = shift_reg;
						end
					end
					default: go_to(PH_IDLE);
				endcase
			end
			if (fin) finished++;

			// bus drive follows the phase reached
			if (seq_phase == PH_RST_LOW || seq_phase == PH_W_LOW || seq_phase == PH_R_LOW)
				r.drive_low = 1'b1;
			else if (seq_phase == PH_W_HOLD)
				r.drive_low = ~shift_reg[0];
			else
				r.drive_low = 1'b0;
			r.busy_res = (seq_phase != PH_IDLE);
			r.done_res = fin;
			r.read_value = last_read;
			r.device_present = present;
			r.presence_timed_out = timed_out;
			expected_status.push_back(r);
		endfunction

		function void flag_mismatch(string name, logic [7:0] want, logic [7:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		endfunction

		// compare one status transfer with the oldest prediction
		function void check_status(logic [15:0] word);
			res_t got;
			res_t want;
			got = res_t'(word[12:0]);
			if (expected_status.size() == 0) begin
				$display("%0t: status %h arrived with nothing expected, expected none, actual %h",
					$time, word, word);
				errors++;
				return;
			end
			want = expected_status.pop_front();
			if (got.drive_low !== want.drive_low)
				flag_mismatch("drive_low", 8'(want.drive_low), 8'(got.drive_low));
			if (got.busy_res !== want.busy_res)
				flag_mismatch("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			if (got.done_res !== want.done_res)
				flag_mismatch("done_res", 8'(want.done_res), 8'(got.done_res));
			if (got.read_value !== want.read_value)
				flag_mismatch("read_value", want.read_value, got.read_value);
			if (got.device_present !== want.device_present)
				flag_mismatch("device_present", 8'(want.device_present),
					8'(got.device_present));
			if (got.presence_timed_out !== want.presence_timed_out)
				flag_mismatch("presence_timed_out", 8'(want.presence_timed_out),
					8'(got.presence_timed_out));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	bus_status_board status_board;
	bit quiet;
	int useful_items;
	int settings_used;
	int cycle_count;

	one_wire_bus_master_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("one_wire_bus_master_top_test failed");
		$finish;
	end

	// offer one item, wait for its transfer, then update the prediction
	task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
			input logic level);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, level, data};
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// ticks matter while busy, commands while idle
		if ((kind == KIND_TICK) == (status_board.seq_phase != PH_IDLE)) useful_items++;
		status_board.take_item(kind, data, level);
	endtask

	task automatic stop_sending();
		@(negedge clk) s_tvalid <= 1'b0;
	endtask

	task automatic wait_results();
		while (status_board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		status_board.write_reg(idx, val);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic write_config(input cfg_t c);
		put_reg(REG_RESET_LOW, c.reset_low_ticks);
		put_reg(REG_PRES_DELAY, c.presence_delay_ticks);
		put_reg(REG_PRES_TIMEOUT, c.presence_timeout_ticks);
		put_reg(REG_SLOT_LOW, {8'd0, c.slot_low_ticks});
		put_reg(REG_WRITE_HOLD, {8'd0, c.write_hold_ticks});
		put_reg(REG_RECOVERY, {8'd0, c.recovery_ticks});
		put_reg(REG_READ_SAMPLE, {8'd0, c.read_sample_ticks});
		put_reg(REG_READ_TAIL, {8'd0, c.read_tail_ticks});
		settings_used++;
	endtask

	// one command followed by ticks until the sequencer is idle again;
	// noisy adds dropped commands, rise glitches and stray sample levels
	task automatic run_op(input logic [1:0] kind, input logic [7:0] data,
			input logic [7:0] read_bits, input int poll_highs, input bit noisy);
		int polls;
		logic lvl;
		polls = 0;
		send_item(kind, data, 1'($urandom_range(0, 1)));
		if (noisy) send_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
		while (status_board.seq_phase != PH_IDLE) begin
			if (noisy && $urandom_range(0, 15) == 0) begin
				send_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				case (status_board.seq_phase)
					PH_RST_POLL: begin
						lvl = (polls < poll_highs);
						polls++;
					end
					PH_RST_RISE, PH_R_RISE:
						lvl = noisy ? ($urandom_range(0, 3) != 0) : 1'b1;
					PH_R_SAMPLE: begin
						if (noisy && $urandom_range(0, 3) == 0)
							lvl = 1'($urandom_range(0, 1));
						else
							lvl = read_bits[status_board.bit_pos];
					end
					default: lvl = 1'($urandom_range(0, 1));
				endcase
				send_item(KIND_TICK, 8'($urandom), lvl);
			end
		end
	endtask

	// status sink with random stalls
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			status_board.check_status(m_tdata);
		end
	end

	// stimulus
	initial begin
		cfg_t c;
		int goal;
		int spread;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_RESET_LOW;
		cfg_data = '0;
		quiet = 1'b0;
		useful_items = 0;
		settings_used = 0;
		status_board = new();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset defaults: ticks while idle, presence, writes and reads
		send_item(KIND_TICK, 8'h00, 1'b0);
		send_item(KIND_TICK, 8'hff, 1'b1);
		run_op(KIND_RESET, 8'h00, 8'h00, 0, 1'b0);
		run_op(KIND_RESET, 8'h00, 8'h00, 5, 1'b1);
		run_op(KIND_WRITE, 8'hff, 8'h00, 0, 1'b1);
		run_op(KIND_WRITE, 8'ha5, 8'h00, 0, 1'b0);
		run_op(KIND_READ, 8'h00, 8'hff, 0, 1'b1);
		run_op(KIND_READ, 8'h00, 8'h5a, 0, 1'b0);
		stop_sending();
		wait_results();

		// zero lengths everywhere, timeout on the first high poll
		c = '0;
		write_config(c);
		run_op(KIND_RESET, 8'h00, 8'h00, 100, 1'b0);
		run_op(KIND_RESET, 8'h00, 8'h00, 0, 1'b1);
		run_op(KIND_WRITE, 8'h3c, 8'h00, 0, 1'b1);
		run_op(KIND_READ, 8'h00, 8'hc3, 0, 1'b1);
		stop_sending();
		wait_results();

		// presence right at the timeout boundary
		c.presence_timeout_ticks = 16'd3;
		write_config(c);
		run_op(KIND_RESET, 8'h00, 8'h00, 3, 1'b0);
		run_op(KIND_RESET, 8'h00, 8'h00, 2, 1'b0);
		stop_sending();
		wait_results();

		// random settings, mostly short phases
		for (int p = 0; p < 6; p++) begin
			spread = (p % 3 == 2) ? 10 : 4;
			c.reset_low_ticks = 16'($urandom_range(0, 2 * spread));
			c.presence_delay_ticks = 16'($urandom_range(0, 2 * spread));
			c.presence_timeout_ticks = 16'($urandom_range(0, 2 * spread));
			c.slot_low_ticks = 8'($urandom_range(0, spread));
			c.write_hold_ticks = 8'($urandom_range(0, spread));
			c.recovery_ticks = 8'($urandom_range(0, spread));
			c.read_sample_ticks = 8'($urandom_range(0, spread));
			c.read_tail_ticks = 8'($urandom_range(0, spread));
			write_config(c);
			goal = useful_items + 20;
			while (useful_items < goal) begin
				quiet = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 7) == 0)
					send_item(KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
				else
					run_op(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
						$urandom_range(0, c.presence_timeout_ticks + 1),
						1'($urandom_range(0, 1)));
			end
			quiet = 1'b0;
			stop_sending();
			wait_results();
		end

		// back to back transfers, widest presence timeout
		quiet = 1'b1;
		c = '0;
		c.reset_low_ticks = 16'd4;
		c.presence_delay_ticks = 16'd2;
		c.presence_timeout_ticks = 16'hffff;
		c.slot_low_ticks = 8'd2;
		c.write_hold_ticks = 8'd2;
		c.recovery_ticks = 8'd2;
		c.read_sample_ticks = 8'd2;
		c.read_tail_ticks = 8'd2;
		write_config(c);
		run_op(KIND_RESET, 8'h00, 8'h00, 40, 1'b0);
		run_op(KIND_WRITE, 8'($urandom), 8'h00, 0, 1'b0);
		run_op(KIND_READ, 8'h00, 8'($urandom), 0, 1'b0);
		stop_sending();
		wait_results();
		quiet = 1'b0;

		repeat (8) @(posedge clk);
		$display("covered %0d effective items and %0d finished operations (%0d timeouts)",
			useful_items, status_board.finished, status_board.timeouts);
		$display("across %0d register settings, zero lengths and a full-width timeout included",
			settings_used);
		if (status_board.pending() != 0)
			$display("%0t: %0d status transfers never arrived, expected 0 pending, actual %0d",
				$time, status_board.pending(), status_board.pending());
		if (status_board.errors == 0 && status_board.pending() == 0) begin
			$display("one_wire_bus_master_top_test passed");
		end else begin
			$display("one_wire_bus_master_top_test failed");
		end
		$finish;
	end
endmodule
